// File: src/rlcbe_pkg.sv
// Shared types and constants for the RGB LED chain bit encoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package rlcbe_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_BIT_PERIOD  = 3'd0,
        CFG_HIGH_ZERO   = 3'd1,
        CFG_HIGH_ONE    = 3'd2,
        CFG_BRIGHTNESS  = 3'd3,
        CFG_PIXEL_COUNT = 3'd4
    } cfg_index_t;

    // Item kinds carried on the input tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int COLOR_W    = 8;
    localparam int TIME_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int WORD_W     = 3 * COLOR_W;
    localparam int BIT_IDX_W  = 5;
    localparam int CFG_DATA_W = 16;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(WORD_W - 1);

    // Register values after reset
    localparam logic [TIME_W-1:0]  RST_BIT_PERIOD  = 16'd80;
    localparam logic [TIME_W-1:0]  RST_HIGH_ZERO   = 16'd25;
    localparam logic [TIME_W-1:0]  RST_HIGH_ONE    = 16'd53;
    localparam logic [COLOR_W-1:0] RST_BRIGHTNESS  = 8'd255;
    localparam logic [COUNT_W-1:0] RST_PIXEL_COUNT = 9'd1;

    localparam int DEFAULT_MAX_PIXELS = 256;

    // One result word
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic pin_level;
    } result_t;

    // Timing registers handed to the bit sequencer
    typedef struct packed {
        logic [TIME_W-1:0] bit_period;
        logic [TIME_W-1:0] high_zero;
        logic [TIME_W-1:0] high_one;
    } timing_t;

endpackage

`default_nettype wire

// File: src/rlcbe_color_scale.sv
// Brightness scaling and green/red/blue packing of one color write.
// Depends on rlcbe_pkg.
`default_nettype none

module rlcbe_color_scale
(
    input  wire logic [rlcbe_pkg::COLOR_W-1:0] red,
    input  wire logic [rlcbe_pkg::COLOR_W-1:0] green,
    input  wire logic [rlcbe_pkg::COLOR_W-1:0] blue,
    input  wire logic [rlcbe_pkg::COLOR_W-1:0] brightness,
    output logic      [rlcbe_pkg::WORD_W-1:0]  frame_word
);

    localparam int PROD_W = 2 * rlcbe_pkg::COLOR_W;

    logic [PROD_W-1:0] red_prod;
    logic [PROD_W-1:0] green_prod;
    logic [PROD_W-1:0] blue_prod;

    // Scale each color, keep the high byte
    assign red_prod   = PROD_W'(red) * PROD_W'(brightness);
    assign green_prod = PROD_W'(green) * PROD_W'(brightness);
    assign blue_prod  = PROD_W'(blue) * PROD_W'(brightness);

    // Pack green first so it leaves first
    assign frame_word = {green_prod[2*rlcbe_pkg::COLOR_W-1:rlcbe_pkg::COLOR_W],
                         red_prod[2*rlcbe_pkg::COLOR_W-1:rlcbe_pkg::COLOR_W],
                         blue_prod[2*rlcbe_pkg::COLOR_W-1:rlcbe_pkg::COLOR_W]};

endmodule

`default_nettype wire

// File: src/rlcbe_bit_sequencer.sv
// Frame state and per-tick line timing: one item processed per step.
// Depends on rlcbe_pkg.
`default_nettype none

module rlcbe_bit_sequencer
#(
    parameter int LEN_W = 9
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire logic                            cmd,
    input  wire logic [rlcbe_pkg::WORD_W-1:0]    color_word,
    input  wire rlcbe_pkg::timing_t              timing,
    input  wire logic [LEN_W-1:0]                chain_len,
    output rlcbe_pkg::result_t                   result
);

    logic [rlcbe_pkg::WORD_W-1:0]    frame_word_reg,    frame_word_next;
    logic [rlcbe_pkg::BIT_IDX_W-1:0] bit_index_reg,     bit_index_next;
    logic [LEN_W-1:0]                pixel_index_reg,   pixel_index_next;
    logic [rlcbe_pkg::TIME_W-1:0]    elapsed_ticks_reg, elapsed_ticks_next;
    logic                            sending_reg,       sending_next;

    logic                            cur_bit;
    logic [rlcbe_pkg::TIME_W-1:0]    high_time;
    logic [rlcbe_pkg::TIME_W-1:0]    bit_len;
    logic [rlcbe_pkg::TIME_W:0]      elapsed_inc;
    logic [LEN_W-1:0]                pixel_inc;

    // Current bit and its timing
    always_comb
    begin
        cur_bit   = frame_word_reg[rlcbe_pkg::LAST_BIT - bit_index_reg];
        high_time = cur_bit ? timing.high_one : timing.high_zero;
        bit_len   = (high_time > timing.bit_period) ? high_time : timing.bit_period;
        if (bit_len == '0)
        begin
            bit_len = rlcbe_pkg::TIME_W'(1);
        end
        elapsed_inc = {1'b0, elapsed_ticks_reg} + (rlcbe_pkg::TIME_W + 1)'(1);
        pixel_inc   = pixel_index_reg + LEN_W'(1);
    end

    // Next state and result for the item at hand
    always_comb
    begin
        frame_word_next    = frame_word_reg;
        bit_index_next     = bit_index_reg;
        pixel_index_next   = pixel_index_reg;
        elapsed_ticks_next = elapsed_ticks_reg;
        sending_next       = sending_reg;
        result.pin_level   = 1'b0;
        result.rejected    = 1'b0;

        if (cmd == rlcbe_pkg::CMD_WRITE)
        begin
            if (sending_reg)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                frame_word_next    = color_word;
                bit_index_next     = '0;
                pixel_index_next   = '0;
                elapsed_ticks_next = '0;
                sending_next       = (chain_len != '0);
            end
        end
        else if (sending_reg)
        begin
            result.pin_level = (elapsed_ticks_reg < high_time);
            if (elapsed_inc >= {1'b0, bit_len})
            begin
                elapsed_ticks_next = '0;
                if (bit_index_reg == rlcbe_pkg::LAST_BIT)
                begin
                    bit_index_next = '0;
                    if (pixel_inc >= chain_len)
                    begin
                        pixel_index_next = '0;
                        sending_next     = 1'b0;
                    end
                    else
                    begin
                        pixel_index_next = pixel_inc;
                    end
                end
                else
                begin
                    bit_index_next = bit_index_reg + rlcbe_pkg::BIT_IDX_W'(1);
                end
            end
            else
            begin
                elapsed_ticks_next = elapsed_inc[rlcbe_pkg::TIME_W-1:0];
            end
        end

        result.busy_res = sending_next;
    end

    // Advance state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_word_reg    <= '0;
            bit_index_reg     <= '0;
            pixel_index_reg   <= '0;
            elapsed_ticks_reg <= '0;
            sending_reg       <= 1'b0;
        end
        else if (step)
        begin
            frame_word_reg    <= frame_word_next;
            bit_index_reg     <= bit_index_next;
            pixel_index_reg   <= pixel_index_next;
            elapsed_ticks_reg <= elapsed_ticks_next;
            sending_reg       <= sending_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rgb_led_chain_bit_encoder.sv
// RGB LED chain bit encoder, top level. Depends on rlcbe_pkg, rlcbe_color_scale
// and rlcbe_bit_sequencer.
// An accepted word waits in the input register; its result goes to the result register.
// Throughput: one item per cycle, result side permitting; the bit sequencer's update
// sets that figure. A stalled result admits one more word, then holds s_axis_tready low.
// Reset (rst_n, async, active low) empties both registers, stops any frame and restores
// the configuration registers to their default values.
`default_nettype none

module rgb_led_chain_bit_encoder
#(
    parameter int MAX_PIXELS = rlcbe_pkg::DEFAULT_MAX_PIXELS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input word
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rlcbe_pkg::WORD_W-1:0]      s_axis_tdata,  // red, green, blue
    input  wire logic                              s_axis_tuser,  // cmd
    // Result word
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // pin_level, busy_res, rejected
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [rlcbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PIX_W = $clog2(MAX_PIXELS + 1);
    localparam int LEN_W = (PIX_W > rlcbe_pkg::COUNT_W) ? PIX_W : rlcbe_pkg::COUNT_W;

    logic [rlcbe_pkg::TIME_W-1:0]  bit_period_reg;
    logic [rlcbe_pkg::TIME_W-1:0]  high_zero_reg;
    logic [rlcbe_pkg::TIME_W-1:0]  high_one_reg;
    logic [rlcbe_pkg::COLOR_W-1:0] brightness_reg;
    logic [rlcbe_pkg::COUNT_W-1:0] pixel_count_reg;

    logic                          in_valid_reg;
    logic                          in_cmd_reg;
    logic [rlcbe_pkg::COLOR_W-1:0] in_red_reg;
    logic [rlcbe_pkg::COLOR_W-1:0] in_green_reg;
    logic [rlcbe_pkg::COLOR_W-1:0] in_blue_reg;

    logic                          res_valid_reg;
    rlcbe_pkg::result_t            res_reg;

    logic                          step;
    logic [rlcbe_pkg::WORD_W-1:0]  color_word;
    logic [LEN_W-1:0]              count_ext;
    logic [LEN_W-1:0]              chain_len;
    rlcbe_pkg::timing_t            timing;
    rlcbe_pkg::result_t            result;
    rlcbe_pkg::cfg_index_t         cfg_sel;

    // Configuration registers, always writable
    assign cfg_ready = 1'b1;
    assign cfg_sel   = rlcbe_pkg::cfg_index_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= rlcbe_pkg::RST_BIT_PERIOD;
            high_zero_reg   <= rlcbe_pkg::RST_HIGH_ZERO;
            high_one_reg    <= rlcbe_pkg::RST_HIGH_ONE;
            brightness_reg  <= rlcbe_pkg::RST_BRIGHTNESS;
            pixel_count_reg <= rlcbe_pkg::RST_PIXEL_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_sel)
                rlcbe_pkg::CFG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                rlcbe_pkg::CFG_HIGH_ZERO:   high_zero_reg   <= cfg_data;
                rlcbe_pkg::CFG_HIGH_ONE:    high_one_reg    <= cfg_data;
                rlcbe_pkg::CFG_BRIGHTNESS:  brightness_reg  <= cfg_data[rlcbe_pkg::COLOR_W-1:0];
                rlcbe_pkg::CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data[rlcbe_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the chain length to the supported pixel count
    assign count_ext = LEN_W'(pixel_count_reg);
    assign chain_len = (count_ext > LEN_W'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS) : count_ext;

    assign timing.bit_period = bit_period_reg;
    assign timing.high_zero  = high_zero_reg;
    assign timing.high_one   = high_one_reg;

    // Process the held word when the result slot is free or draining
    assign step          = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_red_reg   <= s_axis_tdata[rlcbe_pkg::COLOR_W-1:0];
            in_green_reg <= s_axis_tdata[2*rlcbe_pkg::COLOR_W-1:rlcbe_pkg::COLOR_W];
            in_blue_reg  <= s_axis_tdata[3*rlcbe_pkg::COLOR_W-1:2*rlcbe_pkg::COLOR_W];
        end
    end

    rlcbe_color_scale u_color_scale
    (
        .red        (in_red_reg),
        .green      (in_green_reg),
        .blue       (in_blue_reg),
        .brightness (brightness_reg),
        .frame_word (color_word)
    );

    rlcbe_bit_sequencer
    #(
        .LEN_W (LEN_W)
    )
    u_bit_sequencer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (in_cmd_reg),
        .color_word (color_word),
        .timing     (timing),
        .chain_len  (chain_len),
        .result     (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {5'b00000, res_reg.rejected, res_reg.busy_res, res_reg.pin_level};

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for rgb_led_chain_bit_encoder: drives color and tick words,
// predicts every pin level, busy flag and reject flag, and checks each result word.
// Depends on rlcbe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int WORD_W     = rlcbe_pkg::WORD_W;
    localparam int CFG_DATA_W = rlcbe_pkg::CFG_DATA_W;
    localparam int TIME_W     = rlcbe_pkg::TIME_W;
    localparam int COLOR_W    = rlcbe_pkg::COLOR_W;
    localparam int COUNT_W    = rlcbe_pkg::COUNT_W;

    localparam int MAX_CHAIN    = rlcbe_pkg::DEFAULT_MAX_PIXELS;
    localparam int RANDOM_WORDS = 120;
    localparam int RANDOM_PHASES = 4;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 100;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    logic clk = 1'b0;
    logic rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata;   // red, green, blue
    logic                  s_axis_tuser;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // pin_level, busy_res, rejected, zeros
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies used by the line predictor
    logic [TIME_W-1:0]  reg_bit_period;
    logic [TIME_W-1:0]  reg_high_zero;
    logic [TIME_W-1:0]  reg_high_one;
    logic [COLOR_W-1:0] reg_brightness;
    logic [COUNT_W-1:0] reg_pixel_count;

    // Frame state of the line predictor
    logic [WORD_W-1:0] frame_bits;
    int                bit_pos;
    int                pixels_done;
    int                ticks_in_bit;
    logic              frame_active;

    rlcbe_pkg::result_t expected_levels[$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   tx_gap_max = 0;
    int   rx_gap_max = 0;
    int   hold_request = 0;
    logic tx_offering = 1'b0;

    rgb_led_chain_bit_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [COLOR_W-1:0] scaled(input logic [COLOR_W-1:0] c);
        logic [15:0] prod;
        prod = 16'(c) * 16'(reg_brightness);
        return prod[15:8];
    endfunction

    function automatic int chain_len();
        return (reg_pixel_count > MAX_CHAIN) ? MAX_CHAIN : int'(reg_pixel_count);
    endfunction

    // Advance the predicted line by one word and queue the result it causes
    task automatic predict_line_level(input logic cmd, input logic [COLOR_W-1:0] r, g, b);
        rlcbe_pkg::result_t res;
        logic    bit_val;
        int      high_t;
        int      span;
        res = '0;
        if (cmd == rlcbe_pkg::CMD_WRITE)
        begin
            if (frame_active)
                res.rejected = 1'b1;
            else
            begin
                frame_bits   = {scaled(g), scaled(r), scaled(b)};
                bit_pos      = 0;
                pixels_done  = 0;
                ticks_in_bit = 0;
                frame_active = (chain_len() != 0);
            end
        end
        else if (frame_active)
        begin
            bit_val = frame_bits[WORD_W - 1 - bit_pos];
            high_t  = bit_val ? int'(reg_high_one) : int'(reg_high_zero);
            span    = (high_t > int'(reg_bit_period)) ? high_t : int'(reg_bit_period);
            if (span == 0)
                span = 1;
            res.pin_level = (ticks_in_bit < high_t);
            if (ticks_in_bit + 1 >= span)
            begin
                ticks_in_bit = 0;
                bit_pos++;
                if (bit_pos >= WORD_W)
                begin
                    bit_pos = 0;
                    pixels_done++;
                    if (pixels_done >= chain_len())
                    begin
                        pixels_done  = 0;
                        frame_active = 1'b0;
                    end
                end
            end
            else
                ticks_in_bit++;
        end
        res.busy_res = frame_active;
        expected_levels.push_back(res);
    endtask

    // Offer one word after a random gap and wait until it is taken
    task automatic send_word(input logic cmd, input logic [COLOR_W-1:0] r, g, b);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            if (tx_offering)
                s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, g, r};
        tx_offering = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_line_level(cmd, r, g, b);
    endtask

    task automatic send_tick();
        send_word(rlcbe_pkg::CMD_TICK, COLOR_W'($urandom()), COLOR_W'($urandom()),
                  COLOR_W'($urandom()));
    endtask

    task automatic send_color(input logic [COLOR_W-1:0] r, g, b);
        send_word(rlcbe_pkg::CMD_WRITE, r, g, b);
    endtask

    task automatic send_random_color();
        send_color(COLOR_W'($urandom()), COLOR_W'($urandom()), COLOR_W'($urandom()));
    endtask

    // Tick until the predicted frame is over
    task automatic finish_frame();
        while (frame_active)
            send_tick();
    endtask

    // Stop offering and hold until every queued result has come back
    task automatic wait_drain();
        if (tx_offering)
            s_axis_tvalid <= 1'b0;
        tx_offering = 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input rlcbe_pkg::cfg_index_t idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [TIME_W-1:0] bp, hz, ho,
                             input logic [COLOR_W-1:0] br, input logic [COUNT_W-1:0] pc);
        wait_drain();
        write_reg(rlcbe_pkg::CFG_BIT_PERIOD, bp);
        write_reg(rlcbe_pkg::CFG_HIGH_ZERO, hz);
        write_reg(rlcbe_pkg::CFG_HIGH_ONE, ho);
        write_reg(rlcbe_pkg::CFG_BRIGHTNESS, CFG_DATA_W'(br));
        write_reg(rlcbe_pkg::CFG_PIXEL_COUNT, CFG_DATA_W'(pc));
        cfg_valid <= 1'b0;
        reg_bit_period  = bp;
        reg_high_zero   = hz;
        reg_high_one    = ho;
        reg_brightness  = br;
        reg_pixel_count = pc;
    endtask

    task automatic log_mismatch(input string what, input rlcbe_pkg::result_t want,
                                input rlcbe_pkg::result_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s: expected pin=%0b busy=%0b rej=%0b, got pin=%0b busy=%0b rej=%0b",
                     $realtime, what, want.pin_level, want.busy_res, want.rejected,
                     got.pin_level, got.busy_res, got.rejected);
    endtask

    // Result side: check each word against the oldest expectation, then pick the stall
    initial
    begin : result_checker
        int                 stall;
        int                 hold_left;
        rlcbe_pkg::result_t got;
        rlcbe_pkg::result_t want;
        stall = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_axis_tvalid && m_axis_tready)
                begin
                    got = rlcbe_pkg::result_t'(m_axis_tdata[2:0]);
                    if (expected_levels.size() == 0)
                        log_mismatch("result with nothing pending", '0, got);
                    else
                    begin
                        want = expected_levels.pop_front();
                        if (got.pin_level !== want.pin_level ||
                            got.busy_res !== want.busy_res ||
                            got.rejected !== want.rejected)
                            log_mismatch("result mismatch", want, got);
                    end
                    stall = $urandom_range(rx_gap_max, 0);
                end
                if (hold_request > 0)
                begin
                    hold_left = hold_request;
                    hold_request = 0;
                end
                if (hold_left > 0)
                begin
                    m_axis_tready <= 1'b0;
                    hold_left--;
                end
                else if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall--;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // Idle line, the first default-timing bits with a write arriving mid-frame, then
    // shorter timing takes over at once for the rest of the frame
    task automatic test_reset_defaults();
        tx_gap_max = 0;
        rx_gap_max = 4;
        repeat (3) send_tick();
        send_color(8'hFF, 8'hC0, 8'h80);
        send_color(8'h00, 8'hFF, 8'h01);
        repeat (90) send_tick();
        configure(16'd2, 16'd1, 16'd2, 8'd255, 9'd1);
        finish_frame();
        send_tick();
    endtask

    // Color field extremes and brightness extremes on short bit timing
    task automatic test_color_extremes();
        logic [COLOR_W-1:0] colors [5][3];
        int i;
        colors = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hAA, 8'h55, 8'hAA},
                   '{8'h55, 8'hAA, 8'h55}, '{8'h01, 8'h80, 8'hFE}};
        tx_gap_max = 4;
        rx_gap_max = 4;
        configure(16'd2, 16'd1, 16'd2, 8'd255, 9'd1);
        for (i = 0; i < 5; i++)
        begin
            send_color(colors[i][0], colors[i][1], colors[i][2]);
            repeat (5) send_tick();
            send_random_color();
            finish_frame();
        end
        configure(16'd2, 16'd1, 16'd2, 8'd0, 9'd1);
        send_color(8'hFF, 8'hFF, 8'hFF);
        finish_frame();
        configure(16'd2, 16'd1, 16'd2, 8'd128, 9'd1);
        send_random_color();
        finish_frame();
    endtask

    // High time at or above the bit period leaves no low phase
    task automatic test_long_high();
        configure(16'd1, 16'd2, 16'd4, 8'd255, 9'd1);
        send_random_color();
        finish_frame();
        // Zero high times and zero period: each bit is one low tick
        configure(16'd0, 16'd0, 16'd0, 8'd255, 9'd1);
        send_random_color();
        finish_frame();
        // All-zero frame, so a maximal one-bit high time costs nothing
        configure(16'd2, 16'd1, 16'hFFFF, 8'd0, 9'd1);
        send_random_color();
        finish_frame();
    endtask

    // One-tick bits over a multi-pixel chain back to back, an empty chain that never
    // starts, and a chain shortened below the pixels already sent
    task automatic test_full_chain();
        tx_gap_max = 0;
        rx_gap_max = 0;
        configure(16'd1, 16'd1, 16'd1, 8'd255, 9'd0);
        send_random_color();
        send_tick();
        configure(16'd1, 16'd1, 16'd1, 8'd255, 9'd3);
        send_random_color();
        finish_frame();
        send_random_color();
        repeat (30) send_tick();
        configure(16'd1, 16'd1, 16'd1, 8'd255, 9'd1);
        finish_frame();
    endtask

    // Hold off the result side until the input stalls, then drain before going on
    task automatic test_backpressure();
        int i;
        tx_gap_max = 0;
        rx_gap_max = 2;
        configure(16'd5, 16'd2, 16'd4, 8'd200, 9'd1);
        send_random_color();
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
            send_tick();
        wait_drain();
        tx_gap_max = 4;
        send_random_color();
        finish_frame();
    endtask

    // Random settings; mostly complete frames with random colors and stray writes
    task automatic test_random_traffic();
        int phase;
        int counted;
        int pick;
        logic [COLOR_W-1:0] br;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            tx_gap_max = (phase % 3 == 0) ? 0 : 4;
            rx_gap_max = (phase % 4 == 1) ? 0 : 4;
            pick = $urandom_range(3, 0);
            br = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : COLOR_W'($urandom());
            configure(TIME_W'($urandom_range(3, 1)), TIME_W'($urandom_range(2, 1)),
                      TIME_W'($urandom_range(4, 1)), br, COUNT_W'($urandom_range(2, 1)));
            counted = 0;
            while (counted < RANDOM_WORDS / RANDOM_PHASES)
            begin
                pick = $urandom_range(99, 0);
                if (!frame_active && pick < 30)
                begin
                    send_random_color();
                    counted++;
                end
                else if (frame_active && pick < 3)
                begin
                    send_random_color();
                    counted++;
                end
                else
                begin
                    // idle ticks do not count
                    if (frame_active)
                        counted++;
                    send_tick();
                end
            end
            finish_frame();
        end
    endtask

    // Largest timing values; the frame is left running at the end of the run
    task automatic test_extreme_timing();
        int i;
        tx_gap_max = 4;
        rx_gap_max = 4;
        configure(16'hFFFF, 16'hFFFF, 16'd1, 8'd255, 9'd256);
        send_color(8'h3C, 8'hFF, 8'h0F);
        for (i = 0; i < 40; i++)
            send_tick();
        send_random_color();
        repeat (10) send_tick();
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rlcbe_pkg::CMD_TICK;
        cfg_valid     <= 1'b0;
        cfg_index     <= rlcbe_pkg::CFG_BIT_PERIOD;
        cfg_data      <= '0;
        rst_n         <= 1'b0;

        reg_bit_period  = rlcbe_pkg::RST_BIT_PERIOD;
        reg_high_zero   = rlcbe_pkg::RST_HIGH_ZERO;
        reg_high_one    = rlcbe_pkg::RST_HIGH_ONE;
        reg_brightness  = rlcbe_pkg::RST_BRIGHTNESS;
        reg_pixel_count = rlcbe_pkg::RST_PIXEL_COUNT;
        frame_bits   = '0;
        bit_pos      = 0;
        pixels_done  = 0;
        ticks_in_bit = 0;
        frame_active = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_color_extremes();
        test_long_high();
        test_full_chain();
        test_backpressure();
        test_random_traffic();
        test_extreme_timing();

        // Drain, then watch a few more cycles for stray results
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_levels.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
src/rlcbe_pkg.sv
src/rlcbe_color_scale.sv
src/rlcbe_bit_sequencer.sv
src/rgb_led_chain_bit_encoder.sv
tb/sv/tb_top.sv
